// ===== rtl/core/start_delimited_frame_extractor_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the start-delimited frame extractor core
// Concurrent checks that are compiled away in synthesis.
// ----------------------------------------------------------------------------
`ifndef START_DELIMITED_FRAME_EXTRACTOR_CORE_ASSERT_SVH
`define START_DELIMITED_FRAME_EXTRACTOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during reset.
`define SDFE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk and disabled during reset.
`define SDFE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SDFE_ASSERT_SAME(lbl, ante, cons, msg)
`define SDFE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/sdfe_pkg.sv =====
// ----------------------------------------------------------------------------
// sdfe_pkg
// Types, constants and helper functions shared by the frame extractor.
// ----------------------------------------------------------------------------
package sdfe_pkg;

	localparam int MAX_FRAME_LENGTH_DEF = 2048;
	localparam int COUNT_W              = 12;
	localparam int ADDR_W               = 5;
	localparam int DATA_W               = 32;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic [1:0] {
		MODE_HUNT  = 2'd0,
		MODE_FIXED = 2'd1,
		MODE_VAR   = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		REG_START_COUNT  = 3'd0,
		REG_START_FIRST  = 3'd1,
		REG_START_SECOND = 3'd2,
		REG_STOP_COUNT   = 3'd3,
		REG_STOP_SECOND  = 3'd4,
		REG_FIXED_LENGTH = 3'd5,
		REG_MIN_LENGTH   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         start_count;
		logic [7:0]         start_first;
		logic [7:0]         start_second;
		logic [1:0]         stop_count;
		logic [7:0]         stop_second;
		logic [COUNT_W-1:0] fixed_length;
		logic [COUNT_W-1:0] min_length;
	} cfg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       frame_first;
		logic       frame_done;
	} res_t;

	// Up to three results caused by one received byte, in delivery order.
	typedef struct packed {
		res_t [2:0] res;
		logic [1:0] n;
	} grp_t;

	typedef struct packed {
		logic [1:0] left;
		logic       out_take;
	} q_stat_t;

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic res_t mk_res(input logic [7:0] b, input logic v,
		input logic first, input logic done);
		res_t r;
		r.out_byte    = b;
		r.byte_valid  = v;
		r.frame_first = first;
		r.frame_done  = done;
		mk_res = r;
	endfunction

endpackage

// ===== rtl/core/sdfe_cfg.sv =====
// ----------------------------------------------------------------------------
// sdfe_cfg
// APB register bank holding the framing configuration.
// ----------------------------------------------------------------------------
module sdfe_cfg import sdfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_count  <= 2'd1;
			cfg_q.start_first  <= 8'd16;
			cfg_q.start_second <= 8'd0;
			cfg_q.stop_count   <= 2'd0;
			cfg_q.stop_second  <= 8'd3;
			cfg_q.fixed_length <= '0;
			cfg_q.min_length   <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_START_COUNT:  cfg_q.start_count  <= pwdata[1:0];
				REG_START_FIRST:  cfg_q.start_first  <= pwdata[7:0];
				REG_START_SECOND: cfg_q.start_second <= pwdata[7:0];
				REG_STOP_COUNT:   cfg_q.stop_count   <= pwdata[1:0];
				REG_STOP_SECOND:  cfg_q.stop_second  <= pwdata[7:0];
				REG_FIXED_LENGTH: cfg_q.fixed_length <= pwdata[COUNT_W-1:0];
				REG_MIN_LENGTH:   cfg_q.min_length   <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_START_COUNT:  prdata = DATA_W'(cfg_q.start_count);
			REG_START_FIRST:  prdata = DATA_W'(cfg_q.start_first);
			REG_START_SECOND: prdata = DATA_W'(cfg_q.start_second);
			REG_STOP_COUNT:   prdata = DATA_W'(cfg_q.stop_count);
			REG_STOP_SECOND:  prdata = DATA_W'(cfg_q.stop_second);
			REG_FIXED_LENGTH: prdata = DATA_W'(cfg_q.fixed_length);
			REG_MIN_LENGTH:   prdata = DATA_W'(cfg_q.min_length);
			default:          prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/sdfe_parse.sv =====
// ----------------------------------------------------------------------------
// sdfe_parse
// Framing state and the per-byte decode that forms each result group.
// ----------------------------------------------------------------------------
module sdfe_parse import sdfe_pkg::*; #(
	parameter int MAX_FRAME_LENGTH = MAX_FRAME_LENGTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	output grp_t       grp
);

	localparam int LW = $clog2(MAX_FRAME_LENGTH + 1);
	localparam int CW = (LW > COUNT_W) ? LW : COUNT_W;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_FRAME_LENGTH);

	mode_t              mode_q, mode_d;
	logic               hv_q, hv_d;
	logic [7:0]         hb_q, hb_d;
	logic               sm_q, sm_d;
	logic [COUNT_W-1:0] count_q, count_d;

	logic          two, stop_en, fixed_sel, len_ok;
	logic [CW-1:0] start_len, fl, ml, fix_eff, min_eff;
	logic          go_frame, go_two, fixed_done, begin_done;
	logic [1:0]    k;

	assign two       = cfg.start_count[1];
	assign stop_en   = cfg.stop_count[1];
	assign fixed_sel = cfg.fixed_length != '0;
	assign start_len = two ? CW'(2) : CW'(1);
	assign fl        = CW'(cfg.fixed_length);
	assign ml        = CW'(cfg.min_length);
	assign fix_eff   = (fl > MAX_C) ? MAX_C : ((fl < start_len) ? start_len : fl);
	assign min_eff   = (ml > MAX_C) ? MAX_C : ml;
	assign len_ok    = CW'(count_q) >= min_eff;

	always_comb begin
		mode_d     = mode_q;
		hv_d       = hv_q;
		hb_d       = hb_q;
		sm_d       = sm_q;
		count_d    = count_q;
		grp        = '0;
		k          = 2'd0;
		go_frame   = 1'b0;
		go_two     = 1'b0;
		fixed_done = 1'b0;
		begin_done = 1'b0;

		unique case (mode_q)
			MODE_FIXED: begin
				count_d    = sat_inc(count_q);
				fixed_done = CW'(count_d) >= fix_eff;
				grp.res[k] = mk_res(rx_byte, 1'b1, 1'b0, fixed_done);
				k          = k + 2'd1;
				if (fixed_done) begin
					mode_d = MODE_HUNT;
				end
			end
			MODE_VAR: begin
				if (!hv_q) begin
					if (rx_byte == cfg.start_first) begin
						hv_d = 1'b1;
						hb_d = rx_byte;
					end else begin
						grp.res[k] = mk_res(rx_byte, 1'b1, 1'b0, 1'b0);
						k          = k + 2'd1;
						count_d    = sat_inc(count_q);
					end
				end else begin
					hv_d = 1'b0;
					if (!two && rx_byte == hb_q) begin
						// Doubled escape byte: one data byte, two raw bytes.
						grp.res[k] = mk_res(hb_q, 1'b1, 1'b0, 1'b0);
						k          = k + 2'd1;
						count_d    = sat_inc(sat_inc(count_q));
					end else if (!two && stop_en && rx_byte == cfg.stop_second) begin
						grp.res[k] = mk_res(hb_q, 1'b1, 1'b0, 1'b0);
						k          = k + 2'd1;
						grp.res[k] = mk_res(rx_byte, 1'b1, 1'b0, 1'b0);
						k          = k + 2'd1;
						count_d    = sat_inc(sat_inc(count_q));
					end else if (len_ok && (!two || rx_byte == cfg.start_second)) begin
						// A new start ends this frame with a bare marker.
						grp.res[k] = mk_res(8'd0, 1'b0, 1'b0, 1'b1);
						k          = k + 2'd1;
						go_frame   = 1'b1;
						go_two     = two;
					end else begin
						grp.res[k] = mk_res(hb_q, 1'b1, 1'b0, 1'b0);
						k          = k + 2'd1;
						count_d    = sat_inc(count_q);
						if (rx_byte == cfg.start_first) begin
							hv_d = 1'b1;
							hb_d = rx_byte;
						end else begin
							grp.res[k] = mk_res(rx_byte, 1'b1, 1'b0, 1'b0);
							k          = k + 2'd1;
							count_d    = sat_inc(count_d);
						end
					end
				end
			end
			default: begin
				mode_d = MODE_HUNT;
				if (!sm_q) begin
					if (rx_byte == cfg.start_first) begin
						sm_d = 1'b1;
						hb_d = rx_byte;
					end
				end else begin
					sm_d = 1'b0;
					if (two) begin
						if (rx_byte == cfg.start_second) begin
							go_frame = 1'b1;
							go_two   = 1'b1;
						end else if (rx_byte == cfg.start_first) begin
							sm_d = 1'b1;
							hb_d = rx_byte;
						end
					end else if (rx_byte != hb_q &&
						!(stop_en && rx_byte == cfg.stop_second)) begin
						go_frame = 1'b1;
					end
				end
			end
		endcase

		if (go_frame) begin
			begin_done = fixed_sel && (fix_eff == start_len);
			hv_d       = 1'b0;
			sm_d       = 1'b0;
			count_d    = go_two ? COUNT_W'(2) : COUNT_W'(1);
			mode_d     = fixed_sel ? MODE_FIXED : MODE_VAR;
			if (go_two) begin
				grp.res[k] = mk_res(hb_q, 1'b1, 1'b1, 1'b0);
				k          = k + 2'd1;
				grp.res[k] = mk_res(rx_byte, 1'b1, 1'b0, begin_done);
				k          = k + 2'd1;
			end else begin
				grp.res[k] = mk_res(hb_q, 1'b1, 1'b1, begin_done);
				k          = k + 2'd1;
			end
			if (begin_done) begin
				mode_d = MODE_HUNT;
			end
			// With a one-byte start the confirming byte belongs to the new frame, unless the start byte alone completes it.
			if (!go_two) begin
				if (begin_done) begin
					if (rx_byte == cfg.start_first) begin
						sm_d = 1'b1;
						hb_d = rx_byte;
					end
				end else if (fixed_sel) begin
					count_d    = COUNT_W'(2);
					fixed_done = CW'(2) >= fix_eff;
					grp.res[k] = mk_res(rx_byte, 1'b1, 1'b0, fixed_done);
					k          = k + 2'd1;
					if (fixed_done) begin
						mode_d = MODE_HUNT;
					end
				end else if (rx_byte == cfg.start_first) begin
					hv_d = 1'b1;
					hb_d = rx_byte;
				end else begin
					grp.res[k] = mk_res(rx_byte, 1'b1, 1'b0, 1'b0);
					k          = k + 2'd1;
					count_d    = COUNT_W'(2);
				end
			end
		end

		grp.n = k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_HUNT;
			hv_q    <= 1'b0;
			hb_q    <= 8'd0;
			sm_q    <= 1'b0;
			count_q <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			hv_q    <= hv_d;
			hb_q    <= hb_d;
			sm_q    <= sm_d;
			count_q <= count_d;
		end
	end

endmodule

// ===== rtl/core/sdfe_outq.sv =====
// ----------------------------------------------------------------------------
// sdfe_outq
// Result group register and output register; hands out one result per beat.
// ----------------------------------------------------------------------------
module sdfe_outq import sdfe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  grp_t    grp,
	input  logic    rx_valid,
	output logic    rx_ready,
	output logic    res_valid,
	input  logic    res_ready,
	output res_t    res,
	output q_stat_t stat
);

	res_t [2:0] grp_s1;
	logic [1:0] left_q;
	logic [1:0] pos_q;
	res_t       out_q;
	logic       out_valid_q;
	logic       out_take;
	logic       move;
	logic       load;

	assign out_take = !out_valid_q || res_ready;
	assign move     = (left_q != 2'd0) && out_take;
	assign rx_ready = (left_q == 2'd0) || ((left_q == 2'd1) && out_take);
	assign load     = rx_valid && rx_ready;

	assign res_valid     = out_valid_q;
	assign res           = out_q;
	assign stat.left     = left_q;
	assign stat.out_take = out_take;

	always_ff @(posedge clk) begin
		if (load) begin
			grp_s1 <= grp.res;
		end
		if (move) begin
			out_q <= grp_s1[pos_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= 2'd0;
			pos_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				left_q <= grp.n;
				pos_q  <= 2'd0;
			end else if (move) begin
				left_q <= left_q - 2'd1;
				pos_q  <= pos_q + 2'd1;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/start_delimited_frame_extractor_core.sv =====
// ----------------------------------------------------------------------------
// start_delimited_frame_extractor_core
// Cuts start-delimited frames out of a received byte stream.
// ----------------------------------------------------------------------------
// Received bytes enter on the rx channel (rx_valid/rx_ready, one byte per beat).
// Frame bytes leave on the res channel (res_valid/res_ready), one result per
// beat, with byte_valid, frame_first and frame_done flags; a bare end-of-frame
// marker has byte_valid low. One byte can give zero to three results.
// Each accepted byte is decoded combinationally against the framing state and
// its results are written to a result group register; from there the first
// result moves to the output register as soon as that register is free.
// A byte that gives one result can be accepted every cycle while the receiver
// takes results; a byte giving more holds the group register until its last
// result moves on. The receiver may stall at any time: the output register
// holds its result and rx_ready stays low while the group register holds more
// than one result, or holds its last result behind a stalled output register.
// Reset clears the framing state to hunting, empties both registers and loads
// the configuration defaults. Configuration is written over the APB port; the
// user must write it only while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
`include "start_delimited_frame_extractor_core_assert.svh"

module start_delimited_frame_extractor_core import sdfe_pkg::*; #(
	parameter int MAX_FRAME_LENGTH = MAX_FRAME_LENGTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// Configuration port.
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// Received byte stream.
	input  logic              rx_valid,
	output logic              rx_ready,
	input  logic [7:0]        rx_byte,
	// Frame results.
	output logic              res_valid,
	input  logic              res_ready,
	output logic [7:0]        out_byte,
	output logic              byte_valid,
	output logic              frame_first,
	output logic              frame_done
);

	cfg_t    cfg;
	grp_t    grp;
	res_t    res;
	q_stat_t stat;
	logic    accept;

	// A beat on the rx channel advances the framing state.
	assign accept = rx_valid && rx_ready;

	sdfe_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The decoder works on the byte straight from the port; its results
	// are captured by the group register in the output queue.
	sdfe_parse #(
		.MAX_FRAME_LENGTH (MAX_FRAME_LENGTH)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.accept  (accept),
		.rx_byte (rx_byte),
		.grp     (grp)
	);

	sdfe_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp       (grp),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.stat      (stat)
	);

	assign out_byte    = res.out_byte;
	assign byte_valid  = res.byte_valid;
	assign frame_first = res.frame_first;
	assign frame_done  = res.frame_done;

	// A new byte is only taken when at most the last pending result remains.
	`SDFE_ASSERT_SAME(a_accept_room, accept, stat.left <= 2'd1, "byte accepted over pending results")
	// Pending results reach the output register whenever the receiver takes one.
	`SDFE_ASSERT_NEXT(a_drain, (stat.left != 2'd0) && res_ready, res_valid, "pending result not forwarded")
	// An end-of-frame marker is always followed by the first byte of the next frame.
	`SDFE_ASSERT_SAME(a_marker_then_start, (grp.n != 2'd0) && !grp.res[0].byte_valid, (grp.n >= 2'd2) && grp.res[1].frame_first, "marker without following frame start")

endmodule
